// File: sv/sti_pkg.sv
package sti_pkg;

    localparam int COORD_WIDTH_DEF = 21;
    localparam int FIELD_W         = 63;
    localparam int N_FIELDS        = 5;
    localparam int S_TDATA_W       = ((N_FIELDS * FIELD_W + 7) / 8) * 8;
    localparam int M_TDATA_W       = 8;
    localparam int THR_W           = 20;
    localparam logic [THR_W-1:0] THR_RESET = 20'd107374;
    localparam int N_STAGES        = 6;

    typedef enum logic [1:0] {
        AX_X = 2'd0,
        AX_Y = 2'd1,
        AX_Z = 2'd2
    } t_axis;

endpackage

// File: sv/sti_decide.sv
module sti_decide
    import sti_pkg::*;
#(
    parameter int SW = 69
) (
    input  logic signed [SW-1:0]    i_det,
    input  logic signed [SW-1:0]    i_un,
    input  logic signed [SW-1:0]    i_vn,
    input  logic signed [SW-1:0]    i_tn,
    input  logic        [THR_W-1:0] i_thr,
    output logic                    o_hit
);

    localparam int XW = SW + 1;

    logic signed [XW-1:0] w_det;
    logic signed [XW-1:0] w_un;
    logic signed [XW-1:0] w_vn;
    logic signed [XW-1:0] w_tn;
    logic signed [XW-1:0] w_uv;
    logic        [XW-1:0] w_mag;
    logic                 w_neg;
    logic                 w_par;
    logic                 w_vok;

    function automatic logic unit_ratio(input logic signed [XW-1:0] num,
                                        input logic signed [XW-1:0] det,
                                        input logic neg);
        logic signed [XW-1:0] zero;
        zero = '0;
        if (neg) begin
            unit_ratio = (det <= num) && (num <= zero);
        end else begin
            unit_ratio = (zero <= num) && (num <= det);
        end
    endfunction

    always_comb begin
        w_det = {i_det[SW-1], i_det};
        w_un  = {i_un[SW-1], i_un};
        w_vn  = {i_vn[SW-1], i_vn};
        w_tn  = {i_tn[SW-1], i_tn};
        w_uv  = w_un + w_vn;
        w_neg = i_det[SW-1];
        w_mag = w_neg ? XW'(-w_det) : XW'(w_det);
        w_par = w_mag <= {{(XW-THR_W){1'b0}}, i_thr};
        w_vok = w_neg ? (w_vn <= $signed({XW{1'b0}})) : (w_vn >= $signed({XW{1'b0}}));
        o_hit = !w_par && w_vok && unit_ratio(w_un, w_det, w_neg) &&
                unit_ratio(w_uv, w_det, w_neg) && unit_ratio(w_tn, w_det, w_neg);
    end

endmodule

// File: sv/segment_triangle_intersect_core.sv
// Segment/triangle intersection, six register stages.
// A beat passes the difference, partial-product, cross-product, dot-product, sum and
// output registers in that order before its result shows valid on the master side.
// Throughput: one beat per cycle; a stall on the master side holds every stage.
// Reset (i_rst_n low, synchronous): pipeline emptied, threshold back to default.
module segment_triangle_intersect_core
    import sti_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [THR_W-1:0]     i_cfg_wdata,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    // seg_start, seg_end, tri_a, tri_b, tri_c (63 bits each), zero pad
    input  logic [S_TDATA_W-1:0] i_s_tdata,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    // hit, zero pad
    output logic [M_TDATA_W-1:0] o_m_tdata
);

    localparam int W   = COORD_WIDTH;
    localparam int DW  = W + 1;
    localparam int PW  = 2 * DW;
    localparam int CW  = PW + 1;
    localparam int QW  = DW + CW;
    localparam int SW  = QW + 2;

    logic [THR_W-1:0]    r_thr;
    logic [N_STAGES-1:0] r_v;
    logic                w_en;

    // stage 1: differences (dir, e1, e2, s)
    logic signed [DW-1:0] r_dir [3];
    logic signed [DW-1:0] r_e1  [3];
    logic signed [DW-1:0] r_e2  [3];
    logic signed [DW-1:0] r_s   [3];
    // stage 2: cross partial products, vectors carried
    logic signed [PW-1:0] r_pp  [6];
    logic signed [PW-1:0] r_qp  [6];
    logic signed [DW-1:0] r_dir2 [3];
    logic signed [DW-1:0] r_e12  [3];
    logic signed [DW-1:0] r_e22  [3];
    logic signed [DW-1:0] r_s2   [3];
    // stage 3: cross products
    logic signed [CW-1:0] r_p   [3];
    logic signed [CW-1:0] r_q   [3];
    logic signed [DW-1:0] r_dir3 [3];
    logic signed [DW-1:0] r_e13  [3];
    logic signed [DW-1:0] r_e23  [3];
    logic signed [DW-1:0] r_s3   [3];
    // stage 4: dot partial products
    logic signed [QW-1:0] r_dm  [3];
    logic signed [QW-1:0] r_um  [3];
    logic signed [QW-1:0] r_vm  [3];
    logic signed [QW-1:0] r_tm  [3];
    // stage 5: sums
    logic signed [SW-1:0] r_det;
    logic signed [SW-1:0] r_un;
    logic signed [SW-1:0] r_vn;
    logic signed [SW-1:0] r_tn;
    // stage 6: output
    logic                 r_hit;
    logic                 w_hit;

    logic signed [DW-1:0] w_c [N_FIELDS][3];

    assign w_en       = !r_v[N_STAGES-1] || i_m_tready;
    assign o_s_tready = w_en;
    assign o_m_tvalid = r_v[N_STAGES-1];
    assign o_m_tdata  = {{(M_TDATA_W-1){1'b0}}, r_hit};

    always_comb begin
        for (int f = 0; f < N_FIELDS; f++) begin
            for (int k = 0; k < 3; k++) begin
                w_c[f][k] = DW'($signed(i_s_tdata[f*FIELD_W + k*W +: W]));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (i_cfg_we) begin
            r_thr <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_en) begin
            r_v <= {r_v[N_STAGES-2:0], i_s_tvalid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                r_dir[k] <= w_c[1][k] - w_c[0][k];
                r_e1[k]  <= w_c[3][k] - w_c[2][k];
                r_e2[k]  <= w_c[4][k] - w_c[2][k];
                r_s[k]   <= w_c[0][k] - w_c[2][k];
            end

            r_pp[0] <= PW'(r_dir[AX_Y] * r_e2[AX_Z]);
            r_pp[1] <= PW'(r_dir[AX_Z] * r_e2[AX_Y]);
            r_pp[2] <= PW'(r_dir[AX_Z] * r_e2[AX_X]);
            r_pp[3] <= PW'(r_dir[AX_X] * r_e2[AX_Z]);
            r_pp[4] <= PW'(r_dir[AX_X] * r_e2[AX_Y]);
            r_pp[5] <= PW'(r_dir[AX_Y] * r_e2[AX_X]);
            r_qp[0] <= PW'(r_s[AX_Y] * r_e1[AX_Z]);
            r_qp[1] <= PW'(r_s[AX_Z] * r_e1[AX_Y]);
            r_qp[2] <= PW'(r_s[AX_Z] * r_e1[AX_X]);
            r_qp[3] <= PW'(r_s[AX_X] * r_e1[AX_Z]);
            r_qp[4] <= PW'(r_s[AX_X] * r_e1[AX_Y]);
            r_qp[5] <= PW'(r_s[AX_Y] * r_e1[AX_X]);
            r_dir2 <= r_dir;
            r_e12  <= r_e1;
            r_e22  <= r_e2;
            r_s2   <= r_s;

            for (int k = 0; k < 3; k++) begin
                r_p[k] <= CW'(r_pp[2*k]) - CW'(r_pp[2*k+1]);
                r_q[k] <= CW'(r_qp[2*k]) - CW'(r_qp[2*k+1]);
            end
            r_dir3 <= r_dir2;
            r_e13  <= r_e12;
            r_e23  <= r_e22;
            r_s3   <= r_s2;

            for (int k = 0; k < 3; k++) begin
                r_dm[k] <= QW'(r_e13[k] * r_p[k]);
                r_um[k] <= QW'(r_s3[k] * r_p[k]);
                r_vm[k] <= QW'(r_dir3[k] * r_q[k]);
                r_tm[k] <= QW'(r_e23[k] * r_q[k]);
            end

            r_det <= SW'(r_dm[0]) + SW'(r_dm[1]) + SW'(r_dm[2]);
            r_un  <= SW'(r_um[0]) + SW'(r_um[1]) + SW'(r_um[2]);
            r_vn  <= SW'(r_vm[0]) + SW'(r_vm[1]) + SW'(r_vm[2]);
            r_tn  <= SW'(r_tm[0]) + SW'(r_tm[1]) + SW'(r_tm[2]);

            r_hit <= w_hit;
        end
    end

    sti_decide #(
        .SW (SW)
    ) u_decide (
        .i_det (r_det),
        .i_un  (r_un),
        .i_vn  (r_vn),
        .i_tn  (r_tn),
        .i_thr (r_thr),
        .o_hit (w_hit)
    );

endmodule

// File: sv/sti_checker.sv
module sti_checker
    import sti_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_s_tvalid,
    input logic                 o_s_tready,
    input logic                 o_m_tvalid,
    input logic                 i_m_tready,
    input logic [M_TDATA_W-1:0] o_m_tdata
);

    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready == (!o_m_tvalid || i_m_tready))
        else $error("slave ready does not follow master side");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled result beat changed");

    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[M_TDATA_W-1:1] == '0)
        else $error("pad bits set");

    a_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result beat straight after reset");

endmodule

bind segment_triangle_intersect_core sti_checker u_sti_checker (.*);
